// File: rtl/png_scanline_unfilter_assert.svh
// ----------------------------------------------------------------------------
// png_scanline_unfilter_assert.svh
// Assertion macros for the scanline unfilter; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// clocked check, off while reset is high
`define PSU_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// clocked check, also active during reset
`define PSU_ASSERT_NR(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`else

`define PSU_ASSERT(name, clk, rst, prop)

`define PSU_ASSERT_NR(name, clk, prop)

`endif

`endif

// File: rtl/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Shared constants, types and the Paeth predictor for the scanline unfilter.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

   localparam int MAX_ROW_BYTES   = 8192;
   localparam int MAX_PIXEL_BYTES = 8;

   localparam int COL_W         = $clog2(MAX_ROW_BYTES);
   localparam int PIX_IDX_W     = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int ROW_BYTES_W   = 14;
   localparam int PIXEL_BYTES_W = 4;
   localparam int CSR_DATA_W    = 14;
   localparam int CSR_INDEX_W   = 1;

   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_LEVEL_W = $clog2(Q_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_BYTES   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_BYTES = 1'b1;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_kind_type;

   typedef struct packed {
      logic [7:0]           data;
      logic [COL_W-1:0]     col;
      logic                 first;
      filter_kind_type      kind;
      logic                 bad;
      logic                 last;
      logic                 has_left;
      logic [PIX_IDX_W-1:0] pix_idx;
   } entry_type;

   typedef struct packed {
      logic                 full;
      logic [Q_LEVEL_W-1:0] level;
   } q_status_type;

   function automatic logic [7:0] paeth_pick(input logic [7:0] a,
                                             input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [9:0] sa;
      logic signed [9:0] sb;
      logic signed [9:0] sc;
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic [9:0]        pa;
      logic [9:0]        pb;
      logic [9:0]        pc;
      logic [7:0]        pick;
      sa = signed'({2'b00, a});
      sb = signed'({2'b00, b});
      sc = signed'({2'b00, c});
      db = sb - sc;
      da = sa - sc;
      dc = sa + sb - (sc <<< 1);
      pa = db[9] ? 10'(-db) : 10'(db);
      pb = da[9] ? 10'(-da) : 10'(da);
      pc = dc[9] ? 10'(-dc) : 10'(dc);
      if ((pa <= pb) && (pa <= pc)) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

`default_nettype wire

// File: rtl/psu_front.sv
// ----------------------------------------------------------------------------
// psu_front
// Accepts stream bytes, tracks rows and columns, latches the filter type and
// pushes one classified entry per sample byte into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [7:0]                           req_data_byte,
   input  wire logic                                 req_frame_start,
   input  wire logic [psu_pkg::ROW_BYTES_W-1:0]      row_bytes,
   input  wire logic [psu_pkg::PIXEL_BYTES_W-1:0]    pixel_bytes,
   input  wire logic                                 q_full,
   output logic                                      push,
   output psu_pkg::entry_type                        push_entry
);

   logic [psu_pkg::COL_W-1:0]         col_ff;
   logic [psu_pkg::COL_W-1:0]         col_in;
   logic                              await_ff;
   logic                              await_in;
   logic                              first_ff;
   logic                              first_in;
   psu_pkg::filter_kind_type          kind_ff;
   psu_pkg::filter_kind_type          kind_in;
   logic                              bad_ff;
   logic                              bad_in;

   logic                              acc;
   logic                              eff_await;
   logic                              eff_first;
   logic [psu_pkg::COL_W-1:0]         eff_col;
   logic [psu_pkg::ROW_BYTES_W-1:0]   rb_eff;
   logic [psu_pkg::PIXEL_BYTES_W-1:0] pb_eff;
   logic                              last;
   logic                              has_left;

   assign req_stall = q_full;
   assign acc       = req_valid & ~q_full;
   assign eff_await = req_frame_start | await_ff;
   assign eff_first = req_frame_start | first_ff;
   assign eff_col   = req_frame_start ? '0 : col_ff;
   assign push      = acc & ~eff_await;

   always_comb begin
      if (row_bytes == '0) begin
         rb_eff = psu_pkg::ROW_BYTES_W'(1);
      end else if (row_bytes > psu_pkg::ROW_BYTES_W'(psu_pkg::MAX_ROW_BYTES)) begin
         rb_eff = psu_pkg::ROW_BYTES_W'(psu_pkg::MAX_ROW_BYTES);
      end else begin
         rb_eff = row_bytes;
      end
      if (pixel_bytes == '0) begin
         pb_eff = psu_pkg::PIXEL_BYTES_W'(1);
      end else if (pixel_bytes > psu_pkg::PIXEL_BYTES_W'(psu_pkg::MAX_PIXEL_BYTES)) begin
         pb_eff = psu_pkg::PIXEL_BYTES_W'(psu_pkg::MAX_PIXEL_BYTES);
      end else begin
         pb_eff = pixel_bytes;
      end
   end

   assign last     = (psu_pkg::ROW_BYTES_W'(eff_col) + psu_pkg::ROW_BYTES_W'(1)) >= rb_eff;
   assign has_left = psu_pkg::ROW_BYTES_W'(eff_col) >= psu_pkg::ROW_BYTES_W'(pb_eff);

   always_comb begin
      push_entry.data     = req_data_byte;
      push_entry.col      = eff_col;
      push_entry.first    = eff_first;
      push_entry.kind     = kind_ff;
      push_entry.bad      = bad_ff;
      push_entry.last     = last;
      push_entry.has_left = has_left;
      push_entry.pix_idx  = psu_pkg::PIX_IDX_W'(pb_eff - psu_pkg::PIXEL_BYTES_W'(1));
   end

   always_comb begin
      col_in   = col_ff;
      await_in = await_ff;
      first_in = first_ff;
      kind_in  = kind_ff;
      bad_in   = bad_ff;
      if (acc) begin
         if (eff_await) begin
            if (req_data_byte <= 8'(psu_pkg::FILT_PAETH)) begin
               kind_in = psu_pkg::filter_kind_type'(req_data_byte[2:0]);
               bad_in  = 1'b0;
            end else begin
               kind_in = psu_pkg::FILT_NONE;
               bad_in  = 1'b1;
            end
            await_in = 1'b0;
            col_in   = '0;
            first_in = eff_first;
         end else if (last) begin
            col_in   = '0;
            await_in = 1'b1;
            first_in = 1'b0;
         end else begin
            col_in   = eff_col + psu_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         await_ff <= 1'b1;
         first_ff <= 1'b1;
         kind_ff  <= psu_pkg::FILT_NONE;
         bad_ff   <= 1'b0;
      end else begin
         col_ff   <= col_in;
         await_ff <= await_in;
         first_ff <= first_in;
         kind_ff  <= kind_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/psu_queue.sv
// ----------------------------------------------------------------------------
// psu_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire psu_pkg::entry_type   push_entry,
   input  wire logic                 pop,
   output logic                      head_valid,
   output psu_pkg::entry_type        head_entry,
   output psu_pkg::q_status_type     status
);

   psu_pkg::entry_type                slot_ff [psu_pkg::Q_DEPTH];
   logic [psu_pkg::Q_PTR_W-1:0]       wr_ptr_ff;
   logic [psu_pkg::Q_PTR_W-1:0]       wr_ptr_in;
   logic [psu_pkg::Q_PTR_W-1:0]       rd_ptr_ff;
   logic [psu_pkg::Q_PTR_W-1:0]       rd_ptr_in;
   logic [psu_pkg::Q_LEVEL_W-1:0]     level_ff;
   logic [psu_pkg::Q_LEVEL_W-1:0]     level_in;

   assign head_valid   = level_ff != '0;
   assign head_entry   = slot_ff[rd_ptr_ff];
   assign status.full  = level_ff == psu_pkg::Q_LEVEL_W'(psu_pkg::Q_DEPTH);
   assign status.level = level_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + psu_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + psu_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + psu_pkg::Q_LEVEL_W'(push) - psu_pkg::Q_LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: rtl/psu_back.sv
// ----------------------------------------------------------------------------
// psu_back
// Reads the line buffer, rebuilds each byte from its neighbors, writes the
// line buffer back and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire psu_pkg::entry_type  head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_pixel_byte,
   output logic                     rsp_row_end,
   output logic                     rsp_bad_filter
);

   logic [7:0]          line_mem_ff [psu_pkg::MAX_ROW_BYTES];
   logic [7:0]          mem_q_ff;
   logic                fwd_ff;
   logic                fwd_in;
   logic [7:0]          fwd_data_ff;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   psu_pkg::entry_type  s1_ff;

   logic [7:0]          left_ff [psu_pkg::MAX_PIXEL_BYTES];
   logic [7:0]          left_in [psu_pkg::MAX_PIXEL_BYTES];
   logic [7:0]          up_ff   [psu_pkg::MAX_PIXEL_BYTES];
   logic [7:0]          up_in   [psu_pkg::MAX_PIXEL_BYTES];

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [7:0]          pixel_ff;
   logic                row_end_ff;
   logic                bad_ff;

   logic                fire;
   logic [7:0]          a;
   logic [7:0]          b;
   logic [7:0]          c;
   logic [8:0]          avg_sum;
   logic [7:0]          pred;
   logic [7:0]          res;

   assign fire = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign pop  = head_valid & (~s1_valid_ff | fire);

   // same-cycle write and read of one column: take the fresh result
   assign fwd_in = fire & (head_entry.col == s1_ff.col);

   always_comb begin
      b = s1_ff.first ? 8'd0 : (fwd_ff ? fwd_data_ff : mem_q_ff);
      a = s1_ff.has_left ? left_ff[s1_ff.pix_idx] : 8'd0;
      c = (s1_ff.has_left & ~s1_ff.first) ? up_ff[s1_ff.pix_idx] : 8'd0;
      avg_sum = {1'b0, a} + {1'b0, b};
      unique case (s1_ff.kind)
         psu_pkg::FILT_SUB:   pred = a;
         psu_pkg::FILT_UP:    pred = b;
         psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
         psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pick(a, b, c);
         default:             pred = 8'd0;
      endcase
      res = s1_ff.data + pred;
   end

   always_comb begin
      for (int i = 0; i < psu_pkg::MAX_PIXEL_BYTES; i++) begin
         left_in[i] = left_ff[i];
         up_in[i]   = up_ff[i];
      end
      if (fire) begin
         for (int i = psu_pkg::MAX_PIXEL_BYTES - 1; i > 0; i--) begin
            left_in[i] = left_ff[i-1];
            up_in[i]   = up_ff[i-1];
         end
         left_in[0] = res;
         up_in[0]   = b;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pop) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < psu_pkg::MAX_PIXEL_BYTES; i++) begin
            left_ff[i] <= 8'd0;
            up_ff[i]   <= 8'd0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < psu_pkg::MAX_PIXEL_BYTES; i++) begin
            left_ff[i] <= left_in[i];
            up_ff[i]   <= up_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff       <= head_entry;
         mem_q_ff    <= line_mem_ff[head_entry.col];
         fwd_ff      <= fwd_in;
         fwd_data_ff <= res;
      end
      if (fire) begin
         pixel_ff   <= res;
         row_end_ff <= s1_ff.last;
         bad_ff     <= s1_ff.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         line_mem_ff[s1_ff.col] <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = pixel_ff;
   assign rsp_row_end    = row_end_ff;
   assign rsp_bad_filter = bad_ff;

endmodule

`default_nettype wire

// File: rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter reconstruction (None, Sub, Up, Average, Paeth), one byte per
// transfer, with a previous-row line buffer and a short left history.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_data_byte, req_frame_start
//   rsp      out  rsp_valid/rsp_stall  rsp_pixel_byte, rsp_row_end, rsp_bad_filter
//   csr      in   csr_write            csr_index, csr_wdata
//
// One byte accepted per cycle while req_stall is low; a filter type byte gives no result.
// A sample byte passes the queue, then the line buffer read stage, then
// reconstruction into the output register before it shows on rsp.
// Reset clears row tracking, queue and history; the line buffer is not cleared.
// rsp_stall holds the output register, then the reconstruct stage, then the
// four-entry queue; req_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "png_scanline_unfilter_assert.svh"

module png_scanline_unfilter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_data_byte,
   input  wire logic                               req_frame_start,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [7:0]                              rsp_pixel_byte,
   output logic                                    rsp_row_end,
   output logic                                    rsp_bad_filter,
   input  wire logic                               csr_write,
   input  wire logic [psu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [psu_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [psu_pkg::ROW_BYTES_W-1:0]   row_bytes_ff;
   logic [psu_pkg::ROW_BYTES_W-1:0]   row_bytes_in;
   logic [psu_pkg::PIXEL_BYTES_W-1:0] pixel_bytes_ff;
   logic [psu_pkg::PIXEL_BYTES_W-1:0] pixel_bytes_in;

   logic                   q_push;
   psu_pkg::entry_type     q_push_entry;
   logic                   q_pop;
   logic                   q_head_valid;
   psu_pkg::entry_type     q_head_entry;
   psu_pkg::q_status_type  q_status;

   always_comb begin
      row_bytes_in   = row_bytes_ff;
      pixel_bytes_in = pixel_bytes_ff;
      if (csr_write) begin
         if (csr_index == psu_pkg::CSR_ROW_BYTES) begin
            row_bytes_in = csr_wdata[psu_pkg::ROW_BYTES_W-1:0];
         end else begin
            pixel_bytes_in = csr_wdata[psu_pkg::PIXEL_BYTES_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff   <= psu_pkg::ROW_BYTES_W'(1);
         pixel_bytes_ff <= psu_pkg::PIXEL_BYTES_W'(1);
      end else begin
         row_bytes_ff   <= row_bytes_in;
         pixel_bytes_ff <= pixel_bytes_in;
      end
   end

   psu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_frame_start (req_frame_start),
      .row_bytes       (row_bytes_ff),
      .pixel_bytes     (pixel_bytes_ff),
      .q_full          (q_status.full),
      .push            (q_push),
      .push_entry      (q_push_entry)
   );

   psu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .status     (q_status)
   );

   psu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_head_valid),
      .head_entry     (q_head_entry),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_row_end    (rsp_row_end),
      .rsp_bad_filter (rsp_bad_filter)
   );

   `PSU_ASSERT(a_push_has_room, clock, reset, q_push |-> !q_status.full)
   `PSU_ASSERT(a_level_bound, clock, reset, q_status.level <= psu_pkg::Q_DEPTH)
   `PSU_ASSERT(a_pop_has_data, clock, reset, q_pop |-> q_head_valid)
   `PSU_ASSERT_NR(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid)

endmodule

`default_nettype wire
